// ----- src/mrad_pkg.sv -----
// Shared types and constants of the memory region access decoder.
// Holds the command and status codes and the beat that travels down the cell chain.
// Depends on nothing; every other file imports it.
package mrad_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W      = 64;
    localparam int BYTES_W     = 4;
    localparam int IDX_OUT_W   = 4;
    localparam int S_DATA_W    = 136;
    localparam int M_DATA_W    = 72;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_PHYS   = 2'd2,
        CMD_LIN    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_REGION = 3'd1,
        ST_PAST_END  = 3'd2,
        ST_RO_WRITE  = 3'd3,
        ST_FULL      = 3'd4,
        ST_REJECT    = 3'd5
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   size;
        logic                read_only;
        logic                linear;
        logic [BYTES_W-1:0]  bytes;
        logic                is_write;
        logic                wr_en;
        logic [IDX_W-1:0]    tgt;
        logic [ADDR_W-1:0]   lstart;
        status_t             status;
        logic                hit;
        logic [IDX_W-1:0]    idx;
        logic [ADDR_W-1:0]   off;
        logic [ADDR_W-1:0]   len;
        logic                locked;
    } token_t;

    typedef struct packed {
        status_t                status;
        logic [IDX_OUT_W-1:0]   region_index;
        logic [ADDR_W-1:0]      offset;
    } result_t;

endpackage

// ----- src/memory_region_access_decoder.sv -----
// Memory region access decoder.
// Input beats carry a command in s_tuser: clear the region table, append a region, or
// look up a physical or linear address with an access width and a write flag. Every
// input beat yields exactly one result beat on the m_ side with a status, the index of
// the matched or appended region and the offset into it.
// Regions are held in a row of MAX_REGIONS cells. A beat is registered at the input,
// then passes one cell per cycle unless a waiting result stalls the chain; the cell
// it reaches compares it against its entry, and an append is written into the cell
// that receives it. A result comes out of the last cell register into the output
// register, which drives m_tdata.
// Only one beat is in the chain at a time; s_tready is low while it travels.
// A finished result waits in the output register and the next beat can enter meanwhile,
// but the whole chain holds still for as long as a result waits untaken.
// Reset empties the table, drops any beat in flight and leaves m_tvalid low.
// Depends on mrad_pkg, mrad_cell and mrad_check.
module memory_region_access_decoder
    import mrad_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // address, region_size, read_only, special, access_bytes, is_write, one zero pad bit
    input  logic [S_DATA_W-1:0] s_tdata,
    // command
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status, region_index, offset, one zero pad bit
    output logic [M_DATA_W-1:0] m_tdata
);

    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [ADDR_W-1:0] total_reg,  total_next;
    logic [ADDR_W:0]   end_reg,    end_next;
    logic              busy_reg;
    logic              tv0_reg;
    token_t            tok0_reg;
    logic              m_valid_reg;
    result_t           m_res_reg;

    logic              accept;
    logic              adv;
    logic              final_load;
    token_t            in_tok;
    logic [ADDR_W:0]   sum_end;
    logic [ADDR_W:0]   lin_sum;
    logic              is_lin;
    logic              full;
    logic              reject;
    logic [BYTES_W-1:0] raw_bytes;
    result_t           res;

    token_t            tok_chain [MAX_REGIONS+1];
    logic [MAX_REGIONS:0] tv_chain;

    assign s_tready   = !busy_reg;
    assign accept     = s_tvalid && s_tready;
    assign adv        = !(m_valid_reg && !m_tready);
    assign final_load = tv_chain[MAX_REGIONS] && adv;

    always_comb begin
        raw_bytes = s_tdata[133:130];
        is_lin    = !s_tdata[128] && !s_tdata[129];
        sum_end   = {1'b0, s_tdata[63:0]} + {1'b0, s_tdata[127:64]};
        lin_sum   = {1'b0, total_reg} + {1'b0, s_tdata[127:64]};
        full      = (count_reg == CNT_W'(MAX_REGIONS));
        reject    = (s_tdata[127:64] == '0) ||
                    (sum_end[ADDR_W] && (sum_end[ADDR_W-1:0] != '0)) ||
                    ((count_reg != '0) && ({1'b0, s_tdata[63:0]} < end_reg)) ||
                    (is_lin && lin_sum[ADDR_W]);

        in_tok           = '0;
        in_tok.cmd       = cmd_t'(s_tuser);
        in_tok.addr      = s_tdata[63:0];
        in_tok.size      = s_tdata[127:64];
        in_tok.read_only = s_tdata[128];
        in_tok.linear    = is_lin;
        in_tok.is_write  = s_tdata[134];
        in_tok.tgt       = count_reg[IDX_W-1:0];
        in_tok.lstart    = total_reg;
        if (raw_bytes == '0) begin
            in_tok.bytes = BYTES_W'(1);
        end else if (raw_bytes > BYTES_W'(8)) begin
            in_tok.bytes = BYTES_W'(8);
        end else begin
            in_tok.bytes = raw_bytes;
        end
        if (full) begin
            in_tok.status = ST_FULL;
        end else if (reject) begin
            in_tok.status = ST_REJECT;
        end else begin
            in_tok.status = ST_OK;
            in_tok.wr_en  = 1'b1;
        end

        count_next = count_reg;
        total_next = total_reg;
        end_next   = end_reg;
        if (accept) begin
            case (in_tok.cmd)
                CMD_CLEAR: begin
                    count_next = '0;
                    total_next = '0;
                end
                CMD_APPEND: begin
                    if (in_tok.wr_en) begin
                        count_next = count_reg + CNT_W'(1);
                        end_next   = sum_end;
                        if (is_lin) begin
                            total_next = lin_sum[ADDR_W-1:0];
                        end
                    end
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            total_reg   <= '0;
            end_reg     <= '0;
            busy_reg    <= 1'b0;
            tv0_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            total_reg <= total_next;
            end_reg   <= end_next;
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (final_load) begin
                busy_reg <= 1'b0;
            end
            if (accept) begin
                tv0_reg <= 1'b1;
            end else if (adv) begin
                tv0_reg <= 1'b0;
            end
            if (final_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tok0_reg <= in_tok;
        end
        if (final_load) begin
            m_res_reg <= res;
        end
    end

    assign tok_chain[0] = tok0_reg;
    assign tv_chain[0]  = tv0_reg;

    for (genvar k = 0; k < MAX_REGIONS; k++) begin : g_cell
        mrad_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .cell_id (IDX_W'(k)),
            .tv_in   (tv_chain[k]),
            .tok_in  (tok_chain[k]),
            .tv_out  (tv_chain[k+1]),
            .tok_out (tok_chain[k+1])
        );
    end

    mrad_check u_check (
        .tok (tok_chain[MAX_REGIONS]),
        .res (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_res_reg.offset, m_res_reg.region_index, m_res_reg.status};

`ifndef ASSERT_OFF
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tv_chain) <= 1)
        else $error("More than one beat travels in the cell chain.");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (tv_chain == '0))
        else $error("Input is ready while a beat is still in the chain.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("Region count exceeds the table size.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(tv_chain[MAX_REGIONS]))
        else $error("Result appeared without a beat leaving the chain.");
`endif

endmodule

// ----- src/mrad_cell.sv -----
// One region cell of the decoder chain: holds one table entry and compares the passing beat.
// Depends on mrad_pkg for the token type and command codes.
module mrad_cell
    import mrad_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [IDX_W-1:0] cell_id,
    input  logic             tv_in,
    input  token_t           tok_in,
    output logic             tv_out,
    output token_t           tok_out
);

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [ADDR_W-1:0] lstart_reg;
    logic              ro_reg;
    logic              lin_reg;
    logic              valid_reg;
    logic              tv_reg;
    token_t            tok_reg;

    logic [ADDR_W-1:0] op_base;
    logic [ADDR_W:0]   diff;
    logic              in_range;
    logic              elig;
    token_t            tok_next;

    always_comb begin
        op_base  = (tok_in.cmd == CMD_LIN) ? lstart_reg : base_reg;
        diff     = {1'b0, tok_in.addr} - {1'b0, op_base};
        in_range = !diff[ADDR_W] && (diff[ADDR_W-1:0] < len_reg);
        elig     = valid_reg && in_range &&
                   ((tok_in.cmd == CMD_PHYS) || ((tok_in.cmd == CMD_LIN) && lin_reg));
        tok_next = tok_in;
        if (elig && !tok_in.hit) begin
            tok_next.hit    = 1'b1;
            tok_next.idx    = cell_id;
            tok_next.off    = diff[ADDR_W-1:0];
            tok_next.len    = len_reg;
            tok_next.locked = ro_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end else if (adv) begin
            tv_reg <= tv_in;
            if (tv_in && (tok_in.cmd == CMD_CLEAR)) begin
                valid_reg <= 1'b0;
            end else if (tv_in && (tok_in.cmd == CMD_APPEND) && tok_in.wr_en &&
                         (tok_in.tgt == cell_id)) begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tok_reg <= tok_next;
            if (tv_in && (tok_in.cmd == CMD_APPEND) && tok_in.wr_en &&
                (tok_in.tgt == cell_id)) begin
                base_reg   <= tok_in.addr;
                len_reg    <= tok_in.size;
                ro_reg     <= tok_in.read_only;
                lin_reg    <= tok_in.linear;
                lstart_reg <= tok_in.lstart;
            end
        end
    end

    assign tv_out  = tv_reg;
    assign tok_out = tok_reg;

endmodule

// ----- src/mrad_check.sv -----
// Final access check of the decoder: turns the beat leaving the chain into a result.
// Depends on mrad_pkg for the token, result and status types.
module mrad_check
    import mrad_pkg::*;
(
    input  token_t  tok,
    output result_t res
);

    logic [ADDR_W-1:0] room;

    always_comb begin
        room = tok.len - tok.off;
        res  = '0;
        case (tok.cmd)
            CMD_CLEAR: begin
                res.status = ST_OK;
            end
            CMD_APPEND: begin
                res.status = tok.status;
                if (tok.status == ST_OK) begin
                    res.region_index = IDX_OUT_W'(tok.tgt);
                end
            end
            CMD_PHYS, CMD_LIN: begin
                if (!tok.hit) begin
                    res.status = ST_NO_REGION;
                end else begin
                    res.region_index = IDX_OUT_W'(tok.idx);
                    res.offset       = tok.off;
                    if (tok.is_write && tok.locked) begin
                        res.status = ST_RO_WRITE;
                    end else if ({{(ADDR_W-BYTES_W){1'b0}}, tok.bytes} > room) begin
                        res.status = ST_PAST_END;
                    end else begin
                        res.status = ST_OK;
                    end
                end
            end
            default: begin
                res.status = ST_NO_REGION;
            end
        endcase
    end

endmodule
